// ===== sv/eatbv_pkg.sv =====
package eatbv_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int ANG_W         = 17;
    localparam int OUT_W         = 16;
    localparam int TURN_UNITS    = 46080;
    localparam int CW            = 34;
    localparam int ZW            = 32;
    localparam int IDX_W         = 5;

    localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);
    // 2^32 / 46080 = 2^22 / 45; ceil(2^44 / 45) keeps the quotient exact for a < 2^16
    localparam int RECIP_W  = 39;
    localparam int RECIP_SH = 22;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << 44) + 64'd44) / 64'd45);

    typedef logic signed [CW-1:0] q30_t;

    typedef struct packed {
        q30_t             x;
        q30_t             y;
        logic signed [ZW-1:0] z;
        logic [1:0]       quad;
    } cordic_t;

    typedef struct packed {
        cordic_t p;
        cordic_t yw;
        cordic_t r;
    } triple_t;

    function automatic logic [ZW-1:0] atan_turns(input logic [IDX_W-1:0] i);
        logic [ZW-1:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic q30_t mulq30(input q30_t a, input q30_t b);
        logic signed [2*CW-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return q30_t'(p >>> 30);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic signed [CW+1:0] v);
        logic signed [CW+1:0] t;
        t = (v + (36'sd1 <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
        if (t > 36'sd32767)
            return 16'h7FFF;
        else if (t < -36'sd32768)
            return 16'h8000;
        return t[OUT_W-1:0];
    endfunction

endpackage

// ===== sv/eatbv_phase.sv =====
module eatbv_phase (
    input  logic                             clk,
    input  logic                             en,
    input  logic [eatbv_pkg::ANG_W-1:0]      angle,
    output logic [eatbv_pkg::ZW-1:0]         phase
);
    import eatbv_pkg::*;

    logic signed [ANG_W:0]   a1;
    logic [ANG_W-1:0]        red;
    logic [ANG_W-1:0]        red_reg;
    logic [ANG_W+RECIP_W-1:0] prod;

    // Wrap into [0, 46080): input spans at most 1.43 turns either way
    always_comb
    begin
        a1 = {angle[ANG_W-1], angle};
        if (a1 < 0)
            a1 = a1 + 18'sd46080;
        if (a1 < 0)
            a1 = a1 + 18'sd46080;
        if (a1 >= 18'sd46080)
            a1 = a1 - 18'sd46080;
        red = a1[ANG_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            red_reg <= red;
    end

    // floor(a * 2^22 / 45) via reciprocal of 45 scaled by 2^44
    assign prod  = red_reg * RECIP;
    assign phase = prod[RECIP_SH +: ZW];
endmodule

// ===== sv/eatbv_cell.sv =====
module eatbv_cell (
    input  logic                           clk,
    input  logic                           en,
    input  logic [eatbv_pkg::IDX_W-1:0]    step,
    input  eatbv_pkg::triple_t             din,
    output eatbv_pkg::triple_t             dout
);
    import eatbv_pkg::*;

    function automatic cordic_t rot(input cordic_t c, input logic [IDX_W-1:0] i);
        cordic_t o;
        q30_t dx, dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        o = c;
        if (c.z >= 0)
        begin
            o.x = c.x - dx;
            o.y = c.y + dy;
            o.z = c.z - $signed(atan_turns(i));
        end
        else
        begin
            o.x = c.x + dx;
            o.y = c.y - dy;
            o.z = c.z + $signed(atan_turns(i));
        end
        return o;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout.p  <= rot(din.p, step);
            dout.yw <= rot(din.yw, step);
            dout.r  <= rot(din.r, step);
        end
    end
endmodule

// ===== sv/eatbv_combine.sv =====
module eatbv_combine (
    input  logic                    clk,
    input  logic                    en,
    input  eatbv_pkg::triple_t      din,
    output logic [9*eatbv_pkg::OUT_W-1:0] dout
);
    import eatbv_pkg::*;

    function automatic void unfold(input cordic_t c, output q30_t s, output q30_t k);
        case (c.quad)
            2'd1:    begin k = -c.y; s = c.x;  end
            2'd2:    begin k = -c.x; s = -c.y; end
            2'd3:    begin k = c.y;  s = -c.x; end
            default: begin k = c.x;  s = c.y;  end
        endcase
    endfunction

    q30_t sp, cp, sy, cy, sr, cr;
    q30_t sp_reg, cp_reg, sy_reg, cy_reg, sr_reg, cr_reg;
    q30_t spcy_reg, spsy_reg, cpcy_reg, cpsy_reg, srcp_reg, crcp_reg, crsy_reg, crcy_reg;
    q30_t srsy_reg, srcy_reg, sr2_reg, cr2_reg, nsp_reg;
    q30_t srsy2_reg, srcy2_reg, crsy2_reg, crcy2_reg;
    q30_t a_reg, b_reg, c_reg, d_reg;
    logic [OUT_W-1:0] o0, o1, o2, o5, o8;
    logic [OUT_W-1:0] o0_reg, o1_reg, o2_reg, o5_reg, o8_reg;

    always_comb
    begin
        unfold(din.p, sp, cp);
        unfold(din.yw, sy, cy);
        unfold(din.r, sr, cr);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_reg <= sp; cp_reg <= cp; sy_reg <= sy;
            cy_reg <= cy; sr_reg <= sr; cr_reg <= cr;
            // first products
            spcy_reg <= mulq30(sp_reg, cy_reg);
            spsy_reg <= mulq30(sp_reg, sy_reg);
            cpcy_reg <= mulq30(cp_reg, cy_reg);
            cpsy_reg <= mulq30(cp_reg, sy_reg);
            srcp_reg <= mulq30(sr_reg, cp_reg);
            crcp_reg <= mulq30(cr_reg, cp_reg);
            crsy_reg <= mulq30(cr_reg, sy_reg);
            crcy_reg <= mulq30(cr_reg, cy_reg);
            srsy_reg <= mulq30(sr_reg, sy_reg);
            srcy_reg <= mulq30(sr_reg, cy_reg);
            sr2_reg  <= sr_reg;
            cr2_reg  <= cr_reg;
            nsp_reg  <= -sp_reg;
            // triple products
            a_reg <= mulq30(sr2_reg, spcy_reg);
            b_reg <= mulq30(sr2_reg, spsy_reg);
            c_reg <= mulq30(cr2_reg, spcy_reg);
            d_reg <= mulq30(cr2_reg, spsy_reg);
            // hold srsy/srcy/crsy/crcy one extra stage alongside triple products
            srsy2_reg <= srsy_reg;
            srcy2_reg <= srcy_reg;
            crsy2_reg <= crsy_reg;
            crcy2_reg <= crcy_reg;
            o0_reg <= o0; o1_reg <= o1; o2_reg <= o2; o5_reg <= o5; o8_reg <= o8;
            dout <= {o8_reg,
                     to_out(36'(d_reg) - 36'(srcy2_reg)), to_out(36'(c_reg) + 36'(srsy2_reg)),
                     o5_reg,
                     to_out(-36'(b_reg) - 36'(crcy2_reg)),
                     to_out(-36'(a_reg) + 36'(crsy2_reg)),
                     o2_reg, o1_reg, o0_reg};
        end
    end

    assign o0 = to_out(36'(cpcy_reg));
    assign o1 = to_out(36'(cpsy_reg));
    assign o2 = to_out(36'(nsp_reg));
    assign o5 = to_out(-36'(srcp_reg));
    assign o8 = to_out(36'(crcp_reg));
endmodule

// ===== sv/euler_angles_to_basis_vectors_top.sv =====
// Converts a pitch/yaw/roll triple (degrees, 7 fraction bits) into forward, right and
// up unit vectors in Q1.15. Fully pipelined: one word per cycle unless stalled. A result
// passes through the input register, the phase stage, the row of CORDIC cells, four combine
// stages and the output register before it is offered.
// Back-pressure stalls the whole pipeline; the output register holds a result until taken.
module euler_angles_to_basis_vectors_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,   // pitch_angle, yaw_angle, roll_angle, zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // forward_x,y,z, right_x,y,z, up_x,y,z
);
    import eatbv_pkg::*;

    localparam int LAT = CORDIC_STEPS + 6;

    // Pipeline advances only when the output slot is free or being taken
    logic adv;
    logic [LAT-1:0] vld_reg;
    logic [ZW-1:0] ph_p, ph_y, ph_r;
    triple_t chain [CORDIC_STEPS+1];
    logic [9*OUT_W-1:0] res;
    logic [9*OUT_W-1:0] res_reg;
    logic out_vld_reg;

    // A free-running datapath with a result FIFO would need depth LAT; instead stall globally.
    assign adv = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // Datapath registers are clock-enabled through gated input muxing: hold on stall
    logic [55:0] din_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            din_reg <= s_axis_tdata;
    end

    eatbv_phase u_ph_p (.clk(clk), .en(adv), .angle(din_reg[16:0]),  .phase(ph_p));
    eatbv_phase u_ph_y (.clk(clk), .en(adv), .angle(din_reg[33:17]), .phase(ph_y));
    eatbv_phase u_ph_r (.clk(clk), .en(adv), .angle(din_reg[50:34]), .phase(ph_r));

    function automatic cordic_t seed(input logic [ZW-1:0] ph);
        cordic_t c;
        c.x = GAIN_Q30;
        c.y = '0;
        c.z = $signed({2'b00, ph[29:0]});
        c.quad = ph[31:30];
        return c;
    endfunction

    assign chain[0] = '{p: seed(ph_p), yw: seed(ph_y), r: seed(ph_r)};

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        eatbv_cell u_cell (
            .clk  (clk),
            .en   (adv),
            .step (IDX_W'(i)),
            .din  (chain[i]),
            .dout (chain[i+1])
        );
    end

    eatbv_combine u_comb (.clk(clk), .en(adv), .din(chain[CORDIC_STEPS]), .dout(res));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[LAT-2:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = res_reg;

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready));

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));

    a_valid_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(m_axis_tvalid));

    a_data_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !$isunknown(m_axis_tdata));
endmodule

// ===== tb/sv/tb_euler_angles_to_basis_vectors_top.sv =====
module tb_euler_angles_to_basis_vectors_top;
    import eatbv_pkg::*;

    localparam int LATENCY     = CORDIC_STEPS + 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [15:0] up_z;
        logic [15:0] up_y;
        logic [15:0] up_x;
        logic [15:0] right_z;
        logic [15:0] right_y;
        logic [15:0] right_x;
        logic [15:0] forward_z;
        logic [15:0] forward_y;
        logic [15:0] forward_x;
    } basis_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [55:0]  s_axis_tdata;   // pitch_angle, yaw_angle, roll_angle, zero pad
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;   // forward_x,y,z, right_x,y,z, up_x,y,z

    basis_t basis_q[$];
    int     mismatches;
    int     cycles;
    logic   in_fire;
    logic   out_fire;
    logic [143:0] out_word;
    bit     quiet;
    bit     hold_req;

    const string field_names[9] = '{"forward_x", "forward_y", "forward_z",
                                    "right_x", "right_y", "right_z",
                                    "up_x", "up_y", "up_z"};

    euler_angles_to_basis_vectors_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ---------------- predictor ----------------
    function automatic longint asr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return asr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic void angle_sin_cos(input logic [16:0] ang, output longint sn,
                                          output longint cs);
        longint atan_tab[24] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
            64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
            64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
        longint a, phase, x, y, z, dx, dy, t;
        logic [1:0] quad;
        a = longint'($signed(ang));
        a = a % TURN_UNITS;
        if (a < 0)
            a += TURN_UNITS;
        phase = (a <<< 32) / TURN_UNITS;
        quad  = phase[31:30];
        z     = phase & 64'h3FFFFFFF;
        x     = 652032874;
        y     = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
            else
            begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        case (quad)
            2'd1: begin t = x; x = -y; y = t; end
            2'd2: begin x = -x; y = -y; end
            2'd3: begin t = x; x = y; y = -t; end
            default: ;
        endcase
        sn = y;
        cs = x;
    endfunction

    function automatic logic [15:0] q30_to_q15(input longint v);
        int s;
        s = (OUT_FRAC_BITS < 30) ? 30 - OUT_FRAC_BITS : 0;
        if (s > 0)
            v = asr(v + (64'sd1 <<< (s - 1)), s);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic basis_t predict_basis(input logic [16:0] p, input logic [16:0] yw,
                                             input logic [16:0] r);
        longint sp, cp, sy, cy, sr, cr, spcy, spsy;
        basis_t b;
        angle_sin_cos(p, sp, cp);
        angle_sin_cos(yw, sy, cy);
        angle_sin_cos(r, sr, cr);
        spcy = mul_q30(sp, cy);
        spsy = mul_q30(sp, sy);
        b.forward_x = q30_to_q15(mul_q30(cp, cy));
        b.forward_y = q30_to_q15(mul_q30(cp, sy));
        b.forward_z = q30_to_q15(-sp);
        b.right_x   = q30_to_q15(-mul_q30(sr, spcy) + mul_q30(cr, sy));
        b.right_y   = q30_to_q15(-mul_q30(sr, spsy) - mul_q30(cr, cy));
        b.right_z   = q30_to_q15(-mul_q30(sr, cp));
        b.up_x      = q30_to_q15(mul_q30(cr, spcy) + mul_q30(sr, sy));
        b.up_y      = q30_to_q15(mul_q30(cr, spsy) - mul_q30(sr, cy));
        b.up_z      = q30_to_q15(mul_q30(cr, cp));
        return b;
    endfunction

    // ---------------- handshake sampling and checking ----------------
    // Sample between edges so the check never races the DUT registers.
    always @(negedge clk)
    begin
        in_fire  <= s_axis_tvalid && s_axis_tready;
        out_fire <= m_axis_tvalid && m_axis_tready;
        out_word <= m_axis_tdata;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_fire)
        begin
            if (basis_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", out_word);
            end
            else
            begin
                basis_t want;
                want = basis_q.pop_front();
                for (int k = 0; k < 9; k++)
                begin
                    if (out_word[16*k +: 16] !== want[16*k +: 16])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%s mismatch: expected %h, got %h", field_names[k],
                                     want[16*k +: 16], out_word[16*k +: 16]);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_euler_angles_to_basis_vectors_top: done, errors");
            $finish;
        end
    end

    // ---------------- result side ----------------
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            n = quiet ? 0 : $urandom_range(0, 14);
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!out_fire && !hold_req);
        end
    end

    // ---------------- input side ----------------
    task automatic send_angles(input logic [16:0] p, input logic [16:0] yw,
                               input logic [16:0] r);
        int n;
        n = quiet ? 0 : $urandom_range(0, 14);
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, r, yw, p};
        basis_q.push_back(predict_basis(p, yw, r));
        do @(posedge clk); while (!in_fire);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (basis_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [16:0] rand_angle();
        // mostly legal range, sometimes any 17-bit pattern
        if ($urandom_range(0, 4) == 0)
            return 17'($urandom);
        return 17'($signed($urandom_range(0, 92160)) - 46080);
    endfunction

    task automatic test_directed();
        logic [16:0] specials[14] = '{17'd0, 17'd46080, -17'sd46080, 17'd11520, 17'd23040,
                                      17'd34560, -17'sd11520, 17'd5760, 17'h0FFFF,
                                      17'h10000, 17'h1FFFF, 17'd1, 17'd11519, 17'd11521};
        foreach (specials[i])
            send_angles(specials[i], specials[(i + 3) % 14], specials[(i + 7) % 14]);
        send_angles(17'h0FFFF, 17'h0FFFF, 17'h0FFFF);
        send_angles(17'h10000, 17'h10000, 17'h10000);
        send_angles(17'd11520, 17'd0, 17'd0);
        send_angles(-17'sd11520, 17'd23040, 17'd34560);
        wait_drained();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            send_angles(rand_angle(), rand_angle(), rand_angle());
        end
        quiet = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        quiet    = 1'b1;
        for (int i = 0; i < 80; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle());
        quiet = 1'b0;
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 20; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle());
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_angles(rand_angle(), rand_angle(), rand_angle());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        mismatches    = 0;
        cycles        = 0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(500);
        test_backpressure();
        test_drain_pause();
        test_random(510);

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && basis_q.size() == 0)
            $display("tb_euler_angles_to_basis_vectors_top: done, clean");
        else
            $display("tb_euler_angles_to_basis_vectors_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
sv/eatbv_pkg.sv
sv/eatbv_phase.sv
sv/eatbv_cell.sv
sv/eatbv_combine.sv
sv/euler_angles_to_basis_vectors_top.sv
tb/sv/tb_euler_angles_to_basis_vectors_top.sv
